### sv/otf_pkg.sv
// Shared types, widths and codes of the Otsu threshold finder.
`default_nettype none
package otf_pkg;
    localparam int MAX_PIXELS = 4194304;
    localparam int LEVELS     = 256;
    localparam int LVL_W      = 8;
    localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
    localparam int SUM_W      = CNT_W + LVL_W;
    localparam int AB_W       = CNT_W + SUM_W;
    localparam int PR_W       = 2 * CNT_W;
    localparam int D2_W       = 2 * AB_W;
    localparam int MUL_AW     = D2_W;
    localparam int MUL_BW     = AB_W;
    localparam int MUL_PW     = MUL_AW + MUL_BW;
    localparam int STEP_W     = $clog2(MUL_BW + 1);

    typedef logic [LVL_W-1:0]  level_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [SUM_W-1:0]  sum_t;
    typedef logic [AB_W-1:0]   ab_t;
    typedef logic [PR_W-1:0]   pr_t;
    typedef logic [D2_W-1:0]   d2_t;
    typedef logic [MUL_AW-1:0] mul_a_t;
    typedef logic [MUL_BW-1:0] mul_b_t;
    typedef logic [MUL_PW-1:0] mul_p_t;
    typedef logic [STEP_W-1:0] step_t;

    localparam level_t LAST_LEVEL = level_t'(LEVELS - 1);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_PIX_WR, S_SW_RD, S_SW_H, S_MUL, S_OUT
    } state_t;

    typedef enum logic [2:0] {
        OP_HT, OP_A, OP_B, OP_P, OP_D2, OP_LHS, OP_RHS
    } op_t;

    // Request to the shared multiplier.
    typedef struct packed {
        logic   start;
        mul_a_t a;
        mul_b_t b;
    } mul_req_t;
endpackage
`default_nettype wire

### sv/otf_hist_mem.sv
// Histogram memory: one write port, one registered read port.
`default_nettype none
module otf_hist_mem
(
    input  wire                 clk,
    input  wire                 we,
    input  wire otf_pkg::level_t waddr,
    input  wire otf_pkg::cnt_t   wdata,
    input  wire                 re,
    input  wire otf_pkg::level_t raddr,
    output otf_pkg::cnt_t        rdata
);
    otf_pkg::cnt_t mem [otf_pkg::LEVELS];
    otf_pkg::cnt_t rdata_reg;

    // Write and read-first registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

### sv/otf_mul.sv
// Shared shift-add multiplier, one bit of the second operand per cycle.
`default_nettype none
module otf_mul
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire otf_pkg::mul_req_t req,
    output logic                  done,
    output otf_pkg::mul_p_t       product
);
    otf_pkg::mul_p_t acc_reg, acc_next;
    otf_pkg::mul_a_t a_reg;
    otf_pkg::step_t  cnt_reg, cnt_next;
    logic            run_reg, run_next;
    logic            done_reg, done_next;
    logic [otf_pkg::MUL_AW:0] sum;

    // Add the multiplicand into the upper half when the current bit is set.
    assign sum = {1'b0, acc_reg[otf_pkg::MUL_PW-1:otf_pkg::MUL_BW]}
               + (acc_reg[0] ? {1'b0, a_reg} : '0);

    always_comb
    begin
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            acc_next = {{otf_pkg::MUL_AW{1'b0}}, req.b};
            cnt_next = otf_pkg::step_t'(otf_pkg::MUL_BW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            acc_next = {sum, acc_reg[otf_pkg::MUL_BW-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == otf_pkg::step_t'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    // Operand and product registers.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (req.start)
        begin
            a_reg <= req.a;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule
`default_nettype wire

### sv/otsu_threshold_finder.sv
// Otsu threshold finder: histogram build, exact integer sweep, one result per frame.
// After reset a clearing pass writes zero to every histogram bin before the first pixel is taken.
// A counted pixel is a histogram read, then a write; a dropped one only sets the overflow flag.
// After the last beat, the sweep reads and clears each threshold's bin, then runs up to seven
// multiplies on the shared shift-add multiplier.
// The result is held on the master side until taken; reset clears all control state.
`default_nettype none
module otsu_threshold_finder
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] gray
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // [7:0] threshold
    output logic [1:0]  m_tuser    // [0] single_level, [1] overflow
);
    otf_pkg::state_t state_reg, state_next;
    otf_pkg::op_t    op_reg, op_next;
    otf_pkg::level_t clr_reg, clr_next, t_reg, t_next, gray_reg, gray_next;
    otf_pkg::level_t best_t_reg, best_t_next;
    otf_pkg::cnt_t   pix_reg, pix_next, n0_reg, n0_next;
    otf_pkg::sum_t   sall_reg, sall_next, s0_reg, s0_next;
    otf_pkg::ab_t    a_reg, a_next, d_reg, d_next;
    otf_pkg::pr_t    p_reg, p_next, best_p_reg, best_p_next;
    otf_pkg::d2_t    d2_reg, d2_next, best_d2_reg, best_d2_next;
    otf_pkg::mul_p_t lhs_reg, lhs_next;
    logic            ovf_reg, ovf_next, last_reg, last_next, found_reg, found_next;

    logic            mem_we, mem_re, adv, accept, counted;
    otf_pkg::level_t mem_waddr, mem_raddr;
    otf_pkg::cnt_t   mem_wdata, mem_rdata, n1;
    otf_pkg::sum_t   s0_ht, s1;
    otf_pkg::ab_t    b_prod, d_abs;
    otf_pkg::mul_req_t mreq;
    logic            mul_done;
    otf_pkg::mul_p_t prod;

    otf_hist_mem u_mem
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    otf_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mreq),
        .done    (mul_done),
        .product (prod)
    );

    assign accept  = s_tvalid && s_tready;
    assign counted = pix_reg < otf_pkg::cnt_t'(otf_pkg::MAX_PIXELS);

    // Class terms used by the multiply steps.
    assign s0_ht  = s0_reg + otf_pkg::sum_t'(prod);
    assign n1     = pix_reg - n0_reg;
    assign s1     = sall_reg - s0_reg;
    assign b_prod = otf_pkg::ab_t'(prod);
    assign d_abs  = (a_reg >= b_prod) ? (a_reg - b_prod) : (b_prod - a_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            otf_pkg::S_CLEAR:
            begin
                if (clr_reg == otf_pkg::LAST_LEVEL)
                begin
                    state_next = otf_pkg::S_IDLE;
                end
            end
            otf_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (counted)
                    begin
                        state_next = otf_pkg::S_PIX_WR;
                    end
                    else if (s_tlast)
                    begin
                        state_next = otf_pkg::S_SW_RD;
                    end
                end
            end
            otf_pkg::S_PIX_WR:
            begin
                state_next = last_reg ? otf_pkg::S_SW_RD : otf_pkg::S_IDLE;
            end
            otf_pkg::S_SW_RD: state_next = otf_pkg::S_SW_H;
            otf_pkg::S_SW_H:  state_next = otf_pkg::S_MUL;
            otf_pkg::S_MUL:
            begin
                if (adv)
                begin
                    state_next = (t_reg == otf_pkg::LAST_LEVEL) ? otf_pkg::S_OUT
                                                                : otf_pkg::S_SW_RD;
                end
            end
            otf_pkg::S_OUT:
            begin
                if (m_tready)
                begin
                    state_next = otf_pkg::S_IDLE;
                end
            end
            default: state_next = otf_pkg::S_CLEAR;
        endcase
    end

    // Datapath control and register updates.
    always_comb
    begin
        op_next      = op_reg;
        clr_next     = clr_reg;
        t_next       = t_reg;
        gray_next    = gray_reg;
        best_t_next  = best_t_reg;
        pix_next     = pix_reg;
        n0_next      = n0_reg;
        sall_next    = sall_reg;
        s0_next      = s0_reg;
        a_next       = a_reg;
        d_next       = d_reg;
        p_next       = p_reg;
        best_p_next  = best_p_reg;
        d2_next      = d2_reg;
        best_d2_next = best_d2_reg;
        lhs_next     = lhs_reg;
        ovf_next     = ovf_reg;
        last_next    = last_reg;
        found_next   = found_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = t_reg;
        mem_raddr    = t_reg;
        mem_wdata    = '0;
        mreq         = '0;
        adv          = 1'b0;
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;
        unique case (state_reg)
            otf_pkg::S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
            end
            otf_pkg::S_IDLE:
            begin
                s_tready   = 1'b1;
                t_next     = '0;
                n0_next    = '0;
                s0_next    = '0;
                found_next = 1'b0;
                if (accept)
                begin
                    last_next = s_tlast;
                    gray_next = s_tdata;
                    if (counted)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = s_tdata;
                        pix_next  = pix_reg + 1'b1;
                        sall_next = sall_reg + otf_pkg::sum_t'(s_tdata);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            otf_pkg::S_PIX_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = gray_reg;
                mem_wdata = mem_rdata + 1'b1;
            end
            otf_pkg::S_SW_RD:
            begin
                // Read the bin and clear it for the next frame.
                mem_re = 1'b1;
                mem_we = 1'b1;
            end
            otf_pkg::S_SW_H:
            begin
                n0_next    = n0_reg + mem_rdata;
                op_next    = otf_pkg::OP_HT;
                mreq.start = 1'b1;
                mreq.a     = otf_pkg::mul_a_t'(mem_rdata);
                mreq.b     = otf_pkg::mul_b_t'(t_reg);
            end
            otf_pkg::S_MUL:
            begin
                if (mul_done)
                begin
                    case (op_reg)
                        otf_pkg::OP_HT:
                        begin
                            s0_next = s0_ht;
                            if (n0_reg == '0 || n1 == '0)
                            begin
                                adv = 1'b1;
                            end
                            else
                            begin
                                op_next    = otf_pkg::OP_A;
                                mreq.start = 1'b1;
                                mreq.a     = otf_pkg::mul_a_t'(n1);
                                mreq.b     = otf_pkg::mul_b_t'(s0_ht);
                            end
                        end
                        otf_pkg::OP_A:
                        begin
                            a_next     = otf_pkg::ab_t'(prod);
                            op_next    = otf_pkg::OP_B;
                            mreq.start = 1'b1;
                            mreq.a     = otf_pkg::mul_a_t'(n0_reg);
                            mreq.b     = otf_pkg::mul_b_t'(s1);
                        end
                        otf_pkg::OP_B:
                        begin
                            if (d_abs == '0)
                            begin
                                adv = 1'b1;
                            end
                            else
                            begin
                                d_next     = d_abs;
                                op_next    = otf_pkg::OP_P;
                                mreq.start = 1'b1;
                                mreq.a     = otf_pkg::mul_a_t'(n0_reg);
                                mreq.b     = otf_pkg::mul_b_t'(n1);
                            end
                        end
                        otf_pkg::OP_P:
                        begin
                            p_next     = otf_pkg::pr_t'(prod);
                            op_next    = otf_pkg::OP_D2;
                            mreq.start = 1'b1;
                            mreq.a     = otf_pkg::mul_a_t'(d_reg);
                            mreq.b     = otf_pkg::mul_b_t'(d_reg);
                        end
                        otf_pkg::OP_D2:
                        begin
                            d2_next = otf_pkg::d2_t'(prod);
                            if (!found_reg)
                            begin
                                found_next   = 1'b1;
                                best_d2_next = otf_pkg::d2_t'(prod);
                                best_p_next  = p_reg;
                                best_t_next  = t_reg;
                                adv          = 1'b1;
                            end
                            else
                            begin
                                op_next    = otf_pkg::OP_LHS;
                                mreq.start = 1'b1;
                                mreq.a     = otf_pkg::mul_a_t'(prod);
                                mreq.b     = otf_pkg::mul_b_t'(best_p_reg);
                            end
                        end
                        otf_pkg::OP_LHS:
                        begin
                            lhs_next   = prod;
                            op_next    = otf_pkg::OP_RHS;
                            mreq.start = 1'b1;
                            mreq.a     = otf_pkg::mul_a_t'(best_d2_reg);
                            mreq.b     = otf_pkg::mul_b_t'(p_reg);
                        end
                        otf_pkg::OP_RHS:
                        begin
                            // Strictly larger variance replaces the best so far.
                            if (lhs_reg > prod)
                            begin
                                best_d2_next = d2_reg;
                                best_p_next  = p_reg;
                                best_t_next  = t_reg;
                            end
                            adv = 1'b1;
                        end
                        default: adv = 1'b1;
                    endcase
                    if (adv)
                    begin
                        t_next = t_reg + 1'b1;
                    end
                end
            end
            otf_pkg::S_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    pix_next  = '0;
                    sall_next = '0;
                    ovf_next  = 1'b0;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Result fields.
    assign m_tdata = found_reg ? best_t_reg : '0;
    assign m_tuser = {ovf_reg, !found_reg};

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= otf_pkg::S_CLEAR;
            op_reg    <= otf_pkg::OP_HT;
            clr_reg   <= '0;
            t_reg     <= '0;
            pix_reg   <= '0;
            sall_reg  <= '0;
            ovf_reg   <= 1'b0;
            last_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            clr_reg   <= clr_next;
            t_reg     <= t_next;
            pix_reg   <= pix_next;
            sall_reg  <= sall_next;
            ovf_reg   <= ovf_next;
            last_reg  <= last_next;
            found_reg <= found_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        gray_reg    <= gray_next;
        best_t_reg  <= best_t_next;
        n0_reg      <= n0_next;
        s0_reg      <= s0_next;
        a_reg       <= a_next;
        d_reg       <= d_next;
        p_reg       <= p_next;
        best_p_reg  <= best_p_next;
        d2_reg      <= d2_next;
        best_d2_reg <= best_d2_next;
        lhs_reg     <= lhs_next;
    end
endmodule
`default_nettype wire
